// ===== rtl/core/stereo_feedback_delay_macros.svh =====
// Assertion macros shared by the stereo feedback delay checker.
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SFD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define SFD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sfd_pkg.sv =====
// Package with the register map, limits and controller states of the stereo feedback delay.
package sfd_pkg;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 17;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SAMPLES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX       = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN   = 8'd3;

  // Coefficient widths and limits, Q1.15 based.
  localparam int FB_W   = 15;
  localparam int MIX_W  = 16;
  localparam int GAIN_W = 17;
  localparam int WGT_W  = 17;

  localparam logic [FB_W-1:0]   FB_MAX     = 15'd31130;
  localparam logic [MIX_W-1:0]  MIX_ONE    = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

  // Frame controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GAIN
  } sfd_state_t;

endpackage

// ===== rtl/core/sfd_if.sv =====
// Stream and configuration interfaces of the stereo feedback delay.
interface sfd_frame_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_left;
  logic signed [W-1:0] in_right;

  modport source (output valid, in_left, in_right, input ready);
  modport sink   (input valid, in_left, in_right, output ready);
endinterface

interface sfd_result_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_left;
  logic signed [W-1:0] out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

interface sfd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sfd_pkg::CFG_INDEX_W-1:0]    index;
  logic [sfd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/stereo_feedback_delay.sv =====
// Stereo feedback echo: two delay lines in synchronous memories around a shared ring position.
//
// Each stereo frame takes four steps from acceptance to its result in the output
// register: the memory read at the ring position, the feedback and mix multiplies, the
// write-back of the new line sample together with the dry/wet sum, and the output gain
// multiply with rounding and saturation, which waits for a free output register. A
// new frame is accepted in the cycle after the result is loaded, even if that result has
// not yet been taken. The configuration port is always ready and should be written only
// while no frame is in progress. Writing the delay length restarts the ring at position
// zero; the lines read as zero until the ring has wrapped once, so there is no clearing pass
// and frames are accepted right after reset or a delay write.
module stereo_feedback_delay #(
  parameter int MAX_DELAY   = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  sfd_frame_if.sink    frame,
  sfd_result_if.source result,
  sfd_cfg_if.sink      cfg
);
  import sfd_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int FW  = S + 16;
  localparam int MW  = S + 18;
  localparam int GW  = MW + 18;

  // Configuration registers.
  logic [AW-1:0]     last_pos;
  logic [FB_W-1:0]   feedback_gain;
  logic [MIX_W-1:0]  wet_mix;
  logic [GAIN_W-1:0] output_gain;

  // Ring state.
  logic [AW-1:0] line_position;
  logic          wrapped;

  // Controller.
  sfd_state_t state;
  sfd_state_t state_next;
  logic       frame_accept;
  logic       line_write;
  logic       result_load;
  logic       slot_free;

  // Datapath registers.
  logic signed [S-1:0]  x_left;
  logic signed [S-1:0]  x_right;
  logic signed [S-1:0]  rd_left;
  logic signed [S-1:0]  rd_right;
  logic signed [FW-1:0] fbp_left;
  logic signed [FW-1:0] fbp_right;
  logic signed [MW-1:0] dry_left;
  logic signed [MW-1:0] dry_right;
  logic signed [MW-1:0] wet_left;
  logic signed [MW-1:0] wet_right;
  logic signed [MW-1:0] mixed_left;
  logic signed [MW-1:0] mixed_right;
  logic signed [S-1:0]  out_left;
  logic signed [S-1:0]  out_right;
  logic                 out_valid;

  // Combinational datapath.
  logic signed [S-1:0]  d_left;
  logic signed [S-1:0]  d_right;
  logic [WGT_W-1:0]     dry_weight;
  logic signed [FW-1:0] fb_left;
  logic signed [FW-1:0] fb_right;
  logic signed [S-1:0]  line_left;
  logic signed [S-1:0]  line_right;
  logic signed [GW-1:0] gp_left;
  logic signed [GW-1:0] gp_right;
  logic signed [S-1:0]  res_left;
  logic signed [S-1:0]  res_right;
  logic [31:0]          delay_req;
  logic [31:0]          delay_clamped;

  // Delay line storage.
  logic signed [S-1:0] left_mem  [MAX_DELAY];
  logic signed [S-1:0] right_mem [MAX_DELAY];

  // Saturate a wide signed value to the sample width.
  function automatic logic signed [S-1:0] sat(input logic signed [GW-1:0] v);
    logic [GW-S:0] upper;
    upper = v[GW-1:S-1];
    if ((&upper) || !(|upper)) begin
      return v[S-1:0];
    end else if (v[GW-1]) begin
      return {1'b1, {(S-1){1'b0}}};
    end else begin
      return {1'b0, {(S-1){1'b1}}};
    end
  endfunction

  // Handshakes.
  assign frame.ready  = (state == ST_IDLE);
  assign frame_accept = frame.valid && frame.ready;
  assign slot_free    = !out_valid || result.ready;
  assign cfg.ready    = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (frame.valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_GAIN;
      ST_GAIN: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    line_write  = 1'b0;
    result_load = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_MUL:  ;
      ST_SUM:  line_write = 1'b1;
      ST_GAIN: result_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Delay register value clamped to one through MAX_DELAY.
  always_comb begin
    delay_req = 32'(cfg.data);
    if (delay_req == 32'd0) begin
      delay_clamped = 32'd1;
    end else if (delay_req > 32'(MAX_DELAY)) begin
      delay_clamped = 32'(MAX_DELAY);
    end else begin
      delay_clamped = delay_req;
    end
  end

  // Configuration writes and ring position.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos      <= '0;
      feedback_gain <= '0;
      wet_mix       <= '0;
      output_gain   <= GAIN_RESET;
      line_position <= '0;
      wrapped       <= 1'b0;
    end else begin
      if (line_write) begin
        if (line_position == last_pos) begin
          line_position <= '0;
          wrapped       <= 1'b1;
        end else begin
          line_position <= line_position + 1'b1;
        end
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_DELAY_SAMPLES: begin
            last_pos      <= AW'(delay_clamped - 32'd1);
            line_position <= '0;
            wrapped       <= 1'b0;
          end
          REG_FEEDBACK_GAIN: begin
            feedback_gain <= (cfg.data[FB_W-1:0] > FB_MAX) ? FB_MAX : cfg.data[FB_W-1:0];
          end
          REG_WET_MIX: begin
            wet_mix <= (cfg.data[MIX_W-1:0] > MIX_ONE) ? MIX_ONE : cfg.data[MIX_W-1:0];
          end
          REG_OUTPUT_GAIN: begin
            output_gain <= (cfg.data[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX
                                                             : cfg.data[GAIN_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Left line: read at acceptance, write back in the sum cycle.
  always_ff @(posedge clk) begin
    if (line_write) begin
      left_mem[line_position] <= line_left;
    end
    if (frame_accept) begin
      rd_left <= left_mem[line_position];
    end
  end

  // Right line.
  always_ff @(posedge clk) begin
    if (line_write) begin
      right_mem[line_position] <= line_right;
    end
    if (frame_accept) begin
      rd_right <= right_mem[line_position];
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (frame_accept) begin
      x_left  <= frame.in_left;
      x_right <= frame.in_right;
    end
  end

  // Entries not yet written since the last restart read as zero.
  assign d_left     = wrapped ? rd_left : '0;
  assign d_right    = wrapped ? rd_right : '0;
  assign dry_weight = WGT_W'(MIX_ONE) - WGT_W'(wet_mix);

  // Feedback and mix products.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      fbp_left  <= FW'(d_left) * FW'(signed'({1'b0, feedback_gain}));
      fbp_right <= FW'(d_right) * FW'(signed'({1'b0, feedback_gain}));
      dry_left  <= MW'(x_left) * MW'(signed'({1'b0, dry_weight}));
      dry_right <= MW'(x_right) * MW'(signed'({1'b0, dry_weight}));
      wet_left  <= MW'(d_left) * MW'(signed'({1'b0, wet_mix}));
      wet_right <= MW'(d_right) * MW'(signed'({1'b0, wet_mix}));
    end
  end

  // Feedback rounded half up, added to the input and saturated for the line.
  assign fb_left    = (fbp_left + (FW'(1) <<< 14)) >>> 15;
  assign fb_right   = (fbp_right + (FW'(1) <<< 14)) >>> 15;
  assign line_left  = sat(GW'(x_left) + GW'(fb_left));
  assign line_right = sat(GW'(x_right) + GW'(fb_right));

  // Dry/wet sum.
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      mixed_left  <= dry_left + wet_left;
      mixed_right <= dry_right + wet_right;
    end
  end

  // Output gain, one rounding over both scalings, then saturation.
  assign gp_left   = GW'(mixed_left) * GW'(signed'({1'b0, output_gain}));
  assign gp_right  = GW'(mixed_right) * GW'(signed'({1'b0, output_gain}));
  assign res_left  = sat((gp_left + (GW'(1) <<< 29)) >>> 30);
  assign res_right = sat((gp_right + (GW'(1) <<< 29)) >>> 30);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_left  <= res_left;
      out_right <= res_right;
    end
  end

  assign result.valid     = out_valid;
  assign result.out_left  = out_left;
  assign result.out_right = out_right;

endmodule

// ===== rtl/core/sfd_checker.sv =====
// Port-level checker for the stereo feedback delay and its bind to the top level.
`include "stereo_feedback_delay_macros.svh"

module sfd_checker #(
  parameter int W = 16
) (
  input logic         clk,
  input logic         rst,
  input logic         frame_valid,
  input logic         frame_ready,
  input logic         result_valid,
  input logic         result_ready,
  input logic [W-1:0] result_left,
  input logic [W-1:0] result_right
);

  logic frame_txn;
  assign frame_txn = frame_valid && frame_ready;

  // One frame at a time: no new transaction right after one is taken.
  `SFD_ASSERT_NEXT(a_one_frame, frame_txn, !frame_ready, "frame accepted while busy")

  // A result rising in an empty output register follows its frame via MUL, SUM and GAIN.
  `SFD_ASSERT_NOW(a_result_timing, $rose(result_valid), $past(frame_txn, 4),
    "result appeared without a frame four cycles earlier")

  // A result appears only at the end of a busy cycle, never while the input side was idle.
  `SFD_ASSERT_NOW(a_no_invent, $rose(result_valid), !$past(frame_ready),
    "result appeared while the block was idle")

  // A stalled result holds.
  `SFD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(result_left) && $stable(result_right), "stalled result changed")

endmodule

bind stereo_feedback_delay sfd_checker #(.W(SAMPLE_BITS)) u_sfd_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame.valid),
  .frame_ready  (frame.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_left  (result.out_left),
  .result_right (result.out_right)
);
